@@ rtl/ccd_wlm_pkg.sv @@
// Shared types and constants of the CCD window/level mapper.
// Used by ccd_wlm_regs, ccd_wlm_div and ccd_window_level_mapper_top.
package ccd_wlm_pkg;

  localparam int WIN_W      = 10;  // window position / size registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PIX_W      = 16;
  localparam int ADDR_W     = 18;
  localparam int VAL_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] VAL_MAX  = 8'hFF;
  localparam logic [VAL_W-1:0] VAL_ZERO = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_START  = 3'd0,
    REG_COL_END    = 3'd1,
    REG_ROW_START  = 3'd2,
    REG_ROW_END    = 3'd3,
    REG_AUTO_SCALE = 3'd4,
    REG_LOW_LEVEL  = 3'd5,
    REG_HIGH_LEVEL = 3'd6
  } reg_idx_e;

  // Decoded configuration handed to the datapath
  typedef struct packed {
    logic [WIN_W-1:0]      col_start;  // clamped, one-based
    logic [WIN_W-1:0]      row_start;
    logic [WIN_W-1:0]      width;
    logic [WIN_W-1:0]      height;
    logic                  auto_scale;
    logic                  restart;    // window write: restart the frame
    logic                  low_we;
    logic                  high_we;
    logic [CFG_DATA_W-1:0] level;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [ADDR_W-1:0] display_address;
    logic [VAL_W-1:0]  display_value;
    logic              upload_valid;
    logic [BYTE_W-1:0] upload_high_byte;
    logic [BYTE_W-1:0] upload_low_byte;
    logic              frame_done;
    logic [PIX_W-1:0]  frame_minimum;
    logic [PIX_W-1:0]  frame_maximum;
  } res_t;

endpackage

@@ rtl/ccd_wlm_regs.sv @@
// Configuration registers of the window/level mapper, with window clamping.
// Depends on ccd_wlm_pkg.
module ccd_wlm_regs import ccd_wlm_pkg::*; #(
  parameter int IMAGE_SIZE = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [WIN_W-1:0] col_start_q, col_end_q, row_start_q, row_end_q;
  logic             auto_q;
  logic [WIN_W-1:0] cs, ce, rs, re;

  function automatic logic [WIN_W-1:0] clamp_pos(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v == '0) begin
      r = WIN_W'(1);
    end else if (32'(v) > 32'(IMAGE_SIZE)) begin
      r = WIN_W'(IMAGE_SIZE);  // only reached when IMAGE_SIZE fits
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_start_q <= WIN_W'(1);
      col_end_q   <= WIN_W'(512);
      row_start_q <= WIN_W'(1);
      row_end_q   <= WIN_W'(512);
      auto_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COL_START:  col_start_q <= cfg_data_i[WIN_W-1:0];
        REG_COL_END:    col_end_q   <= cfg_data_i[WIN_W-1:0];
        REG_ROW_START:  row_start_q <= cfg_data_i[WIN_W-1:0];
        REG_ROW_END:    row_end_q   <= cfg_data_i[WIN_W-1:0];
        REG_AUTO_SCALE: auto_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cs = clamp_pos(col_start_q);
    ce = clamp_pos(col_end_q);
    rs = clamp_pos(row_start_q);
    re = clamp_pos(row_end_q);
    if (ce < cs) ce = cs;
    if (re < rs) re = rs;

    cfg_o.col_start  = cs;
    cfg_o.row_start  = rs;
    cfg_o.width      = ce - cs + WIN_W'(1);
    cfg_o.height     = re - rs + WIN_W'(1);
    cfg_o.auto_scale = auto_q;
    cfg_o.restart    = cfg_we_i && (cfg_index_i == REG_COL_START ||
                                    cfg_index_i == REG_COL_END   ||
                                    cfg_index_i == REG_ROW_START ||
                                    cfg_index_i == REG_ROW_END);
    cfg_o.low_we     = cfg_we_i && (cfg_index_i == REG_LOW_LEVEL);
    cfg_o.high_we    = cfg_we_i && (cfg_index_i == REG_HIGH_LEVEL);
    cfg_o.level      = cfg_data_i;
  end

endmodule

@@ rtl/ccd_wlm_div.sv @@
// Radix-2 restoring divider: one quotient bit per cycle, VAL_W quotient bits in all.
// Needs num < den so the quotient fits VAL_W bits. Depends on ccd_wlm_pkg.
module ccd_wlm_div import ccd_wlm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PIX_W-1:0] num_i,
  input  logic [PIX_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [VAL_W-1:0] quot_o
);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [PIX_W-1:0]  rem_q, den_q;
  logic [VAL_W-1:0]  quot_q;
  logic [PIX_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, 1'b0};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(VAL_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      quot_q <= {quot_q[VAL_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (step_q == STEP_W'(VAL_W - 1));
  assign quot_o = {quot_q[VAL_W-2:0], ge};

endmodule

@@ rtl/ccd_window_level_mapper_top.sv @@
// Top level of the CCD window/level mapper: sequencer, counters, levels, output register.
// Depends on ccd_wlm_pkg, ccd_wlm_regs and ccd_wlm_div.
//
// Usage:
//   Pixels of the readout window enter on in_valid_i/in_ready_o in row order,
//   with an upload request bit. Each item gives one result on out_valid_o/
//   out_ready_i: transposed display address, 8-bit window/level value, the raw
//   bytes when upload is requested, and frame minimum/maximum on the last pixel.
//   Timing: in_ready_o is high only while the sequencer is idle. A pixel that
//   falls strictly between the low and high levels runs through the serial
//   divider, one quotient bit per cycle over its 8 steps, in the divide state.
//   Other pixels go straight to the write-back state. Every result is held in
//   the work register and moves into the output register in the write-back
//   state, after which the sequencer is idle again.
//   A finished result sits in the output register while the next item is
//   worked on; if the receiver still stalls, the sequencer holds the new result
//   and keeps in_ready_o low until the output register frees up.
//   Reset clears the frame position, the running minimum and maximum, and loads
//   the default window and levels. Configuration is a plain write port
//   (cfg_we_i, cfg_index_i, cfg_data_i), written while no item is in flight.
module ccd_window_level_mapper_top import ccd_wlm_pkg::*; #(
  parameter int IMAGE_SIZE = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  upload_request_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ADDR_W-1:0]     display_address_o,
  output logic [VAL_W-1:0]      display_value_o,
  output logic                  upload_valid_o,
  output logic [BYTE_W-1:0]     upload_high_byte_o,
  output logic [BYTE_W-1:0]     upload_low_byte_o,
  output logic                  frame_done_o,
  output logic [PIX_W-1:0]      frame_minimum_o,
  output logic [PIX_W-1:0]      frame_maximum_o
);

  localparam int CNT_W = ($clog2(IMAGE_SIZE) > WIN_W) ? WIN_W : $clog2(IMAGE_SIZE);
  localparam logic [PIX_W-1:0] PIXEL_MAX = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_WB   = 3'b100
  } state_e;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [PIX_W-1:0] low_q, low_d, high_q, high_d;
  logic [PIX_W-1:0] min_q, min_d, max_q, max_d;
  res_t             work_q, work_d, out_q;
  logic             out_valid_q, out_valid_d, out_load;

  logic             accept;
  logic [PIX_W-1:0] pix, new_min, new_max, span, diff;
  logic [WIN_W-1:0] col_eff, row_eff, col_pos, row_pos;
  logic             last_col, last_row, done;
  logic [31:0]      addr_full;
  logic             need_div;
  logic [VAL_W-1:0] quick_val;

  logic             div_start, div_busy, div_done;
  logic [VAL_W-1:0] div_quot;

  ccd_wlm_regs #(
    .IMAGE_SIZE(IMAGE_SIZE)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ccd_wlm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (diff),
    .den_i  (span),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Per-pixel datapath, evaluated in the accept cycle
  always_comb begin
    pix     = pixel_value_i & PIXEL_MAX;
    col_eff = (WIN_W'(col_q) >= cfg.width)  ? '0 : WIN_W'(col_q);
    row_eff = (WIN_W'(row_q) >= cfg.height) ? '0 : WIN_W'(row_q);
    last_col = (col_eff + WIN_W'(1)) == cfg.width;
    last_row = (row_eff + WIN_W'(1)) == cfg.height;
    done     = last_col && last_row;

    col_pos   = col_eff + cfg.col_start - WIN_W'(1);
    row_pos   = row_eff + cfg.row_start - WIN_W'(1);
    addr_full = 32'(col_pos) * 32'(IMAGE_SIZE) + 32'(row_pos);

    new_min = (pix < min_q) ? pix : min_q;
    new_max = (pix > max_q) ? pix : max_q;

    span = high_q - low_q;
    diff = pix - low_q;

    // Level repair, below black and saturation settle without the divider
    need_div  = 1'b0;
    quick_val = VAL_ZERO;
    priority if (high_q <= low_q) begin
      quick_val = (pix > low_q) ? VAL_MAX : VAL_ZERO;
    end else if (pix <= low_q) begin
      quick_val = VAL_ZERO;
    end else if (pix >= high_q) begin
      quick_val = VAL_MAX;
    end else begin
      need_div = 1'b1;
    end
  end

  assign div_start = accept && need_div;
  assign out_load  = (state_q == S_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    low_d       = low_q;
    high_d      = high_q;
    min_d       = min_q;
    max_d       = max_q;
    work_d      = work_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          work_d.display_address  = addr_full[ADDR_W-1:0];
          work_d.display_value    = quick_val;
          work_d.upload_valid     = upload_request_i;
          work_d.upload_high_byte = upload_request_i ? pix[15:8] : '0;
          work_d.upload_low_byte  = upload_request_i ? pix[7:0] : '0;
          work_d.frame_done       = done;
          work_d.frame_minimum    = done ? new_min : '0;
          work_d.frame_maximum    = done ? new_max : '0;
          state_d = need_div ? S_DIV : S_WB;

          if (done) begin
            if (cfg.auto_scale) begin
              low_d  = new_min;
              high_d = new_max;
            end
            min_d = PIXEL_MAX;
            max_d = '0;
            col_d = '0;
            row_d = '0;
          end else begin
            min_d = new_min;
            max_d = new_max;
            if (last_col) begin
              col_d = '0;
              row_d = CNT_W'(row_eff + WIN_W'(1));
            end else begin
              col_d = CNT_W'(col_eff + WIN_W'(1));
              row_d = CNT_W'(row_eff);
            end
          end
        end else begin
          if (cfg.restart) begin
            min_d = PIXEL_MAX;
            max_d = '0;
            col_d = '0;
            row_d = '0;
          end
          if (cfg.low_we)  low_d  = cfg.level & PIXEL_MAX;
          if (cfg.high_we) high_d = cfg.level & PIXEL_MAX;
        end
      end
      S_DIV: begin
        if (div_done) begin
          work_d.display_value = div_quot;
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      low_q       <= '0;
      high_q      <= PIXEL_MAX;
      min_q       <= PIXEL_MAX;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      low_q       <= low_d;
      high_q      <= high_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (out_load) out_q <= work_q;
  end

  assign out_valid_o        = out_valid_q;
  assign display_address_o  = out_q.display_address;
  assign display_value_o    = out_q.display_value;
  assign upload_valid_o     = out_q.upload_valid;
  assign upload_high_byte_o = out_q.upload_high_byte;
  assign upload_low_byte_o  = out_q.upload_low_byte;
  assign frame_done_o       = out_q.frame_done;
  assign frame_minimum_o    = out_q.frame_minimum;
  assign frame_maximum_o    = out_q.frame_maximum;

`ifndef NO_ASSERTIONS
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("item accepted while the divider is busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_col_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WIN_W'(col_q) < cfg.width)
    else $error("column counter outside the window");

  a_frame_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (frame_minimum_o <= frame_maximum_o))
    else $error("frame minimum above frame maximum");
`endif

endmodule
